@@ rtl/cwsd_pkg.sv @@
// ----------------------------------------------------------------------------
// cwsd_pkg
// Shared types, codes and the character table of the word stream decoder.
// ----------------------------------------------------------------------------
package cwsd_pkg;

  // result kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_NUM   = 2'd2;

  // pending literal codes
  localparam logic [1:0] PL_NONE = 2'd0;
  localparam logic [1:0] PL_NUM  = 2'd1;
  localparam logic [1:0] PL_VAR  = 2'd2;

  // tags with special handling
  localparam logic [3:0] TAG_EXTEND  = 4'd0;
  localparam logic [3:0] TAG_FIRST   = 4'd1;
  localparam logic [3:0] TAG_LIT_A   = 4'd2;
  localparam logic [3:0] TAG_LIT_B   = 4'd5;
  localparam logic [3:0] TAG_NUM_A   = 4'd6;
  localparam logic [3:0] TAG_NUM_B   = 4'd8;
  localparam logic [3:0] TAG_VAR     = 4'd12;
  localparam logic [3:0] TAG_NUM_C   = 4'd15;
  localparam logic [4:0] TAG_VAR_VAL = 5'd4;

  localparam int QUEUE_DEPTH = 2;

  // one classified word, handed from front to back
  typedef struct packed {
    logic        has_start;
    logic [4:0]  tag;
    logic [27:0] text;
    logic        has_num;
    logic [31:0] value;
    logic        hex;
  } cmd_t;

  function automatic logic [6:0] sym_char(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd0:  c = " ";
      6'd1:  c = "r";
      6'd2:  c = "t";
      6'd3:  c = "o";
      6'd4:  c = "e";
      6'd5:  c = "a";
      6'd6:  c = "n";
      6'd7:  c = "i";
      6'd8:  c = "s";
      6'd9:  c = "m";
      6'd10: c = "c";
      6'd11: c = "y";
      6'd12: c = "l";
      6'd13: c = "g";
      6'd14: c = "f";
      6'd15: c = "w";
      6'd16: c = "d";
      6'd17: c = "v";
      6'd18: c = "p";
      6'd19: c = "b";
      6'd20: c = "h";
      6'd21: c = "x";
      6'd22: c = "u";
      6'd23: c = "q";
      6'd24: c = "0";
      6'd25: c = "1";
      6'd26: c = "2";
      6'd27: c = "3";
      6'd28: c = "4";
      6'd29: c = "5";
      6'd30: c = "6";
      6'd31: c = "7";
      6'd32: c = "8";
      6'd33: c = "9";
      6'd34: c = "j";
      6'd35: c = "-";
      6'd36: c = "k";
      6'd37: c = ".";
      6'd38: c = "z";
      6'd39: c = "/";
      6'd40: c = ";";
      6'd41: c = ":";
      6'd42: c = "!";
      6'd43: c = "+";
      6'd44: c = "@";
      6'd45: c = "*";
      6'd46: c = ",";
      6'd47: c = "?";
      default: c = 8'h00;
    endcase
    return c[6:0];
  endfunction

endpackage

@@ rtl/colorforth_word_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// colorforth_word_stream_decoder
// Splits a stream of 32-bit source words into token, character and number
// results.
// ----------------------------------------------------------------------------
// Input channel: word with word_valid; the block drives word_stall. A word
//   is taken at an edge with word_valid high and word_stall low.
// Output channel: kind, tag, char_code, value, hex, last with result_valid;
//   the receiver drives result_stall. last marks the final result of a word.
// The front end takes one word per cycle into a two-entry command queue and
// stalls only when that queue is full. The back end loads a command once it
// has sent all results of the previous one, then sends its results at one per
// cycle through the output register unless stalled; a word gives n results
// (0 to 8; a long text word gives a token start and up to seven characters).
// That back-end result rate sets the sustained throughput. From an empty
// queue, a word passes the queue and the back-end registers before it reaches
// the output register. A stalled result holds there; the back end waits and
// the queue fills, then word_stall rises. Reset clears the queue, the output
// valid and the literal, first-word and block position state.
// ----------------------------------------------------------------------------
module colorforth_word_stream_decoder import cwsd_pkg::*; #(
  parameter int BLOCK_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] word,
  input  logic        word_valid,
  output logic        word_stall,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [4:0]  tag,
  output logic [6:0]  char_code,
  output logic [31:0] value,
  output logic        hex,
  output logic        last
);

  cmd_t front_cmd, head_cmd;
  logic accept, q_full, q_nonempty, q_pop;

  assign word_stall = q_full;
  assign accept     = word_valid && !q_full;

  cwsd_front #(
    .BLOCK_WORDS(BLOCK_WORDS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .word   (word),
    .accept (accept),
    .cmd    (front_cmd)
  );

  cwsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_cmd (head_cmd)
  );

  cwsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_cmd        (head_cmd),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .tag          (tag),
    .char_code    (char_code),
    .value        (value),
    .hex          (hex),
    .last         (last)
  );

endmodule

@@ rtl/cwsd_front.sv @@
// ----------------------------------------------------------------------------
// cwsd_front
// Accepts source words, tracks literal and block position state, and turns
// each word into one command for the back end.
// ----------------------------------------------------------------------------
module cwsd_front import cwsd_pkg::*; #(
  parameter int BLOCK_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] word,
  input  logic        accept,
  output cmd_t        cmd
);

  localparam int IDX_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_WORDS - 1);

  logic [1:0]       pending_literal, pending_literal_next;
  logic [4:0]       pending_tag, pending_tag_next;
  logic             pending_hex, pending_hex_next;
  logic             first_word;
  logic [IDX_W-1:0] word_index;

  logic        block_end;
  logic [31:0] w;
  logic [3:0]  tag4;
  logic [4:0]  tag5;

  assign block_end = (word_index == LAST_IDX);

  always_comb begin
    w = word;
    if (first_word && word[3:0] == TAG_EXTEND) begin
      w[3:0] = TAG_FIRST;
    end
    tag4 = w[3:0];
    tag5 = w[4:0];

    cmd                  = '0;
    pending_literal_next = PL_NONE;
    pending_tag_next     = '0;
    pending_hex_next     = 1'b0;

    if (pending_literal != PL_NONE) begin
      // literal word: taken whole, never decoded by tag
      cmd.has_start = (pending_literal == PL_VAR);
      cmd.tag       = pending_tag;
      cmd.has_num   = 1'b1;
      cmd.value     = word;
      cmd.hex       = pending_hex;
    end else begin
      case (tag4)
        TAG_EXTEND: begin
          cmd.tag  = 5'd0;
          cmd.text = w[31:4];
        end
        TAG_LIT_A, TAG_LIT_B: begin
          cmd.has_start = 1'b1;
          cmd.tag       = tag5;
          if (!block_end) begin
            pending_literal_next = PL_NUM;
            pending_tag_next     = tag5;
            pending_hex_next     = w[4];
          end
        end
        TAG_NUM_A, TAG_NUM_B, TAG_NUM_C: begin
          cmd.has_start = 1'b1;
          cmd.tag       = tag5;
          cmd.has_num   = 1'b1;
          cmd.value     = {5'd0, w[31:5]};
          cmd.hex       = w[4];
        end
        TAG_VAR: begin
          cmd.has_start = 1'b1;
          cmd.tag       = {1'b0, tag4};
          cmd.text      = w[31:4];
          if (!block_end) begin
            pending_literal_next = PL_VAR;
            pending_tag_next     = TAG_VAR_VAL;
          end
        end
        default: begin
          cmd.has_start = 1'b1;
          cmd.tag       = {1'b0, tag4};
          cmd.text      = w[31:4];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_literal <= PL_NONE;
      pending_tag     <= '0;
      pending_hex     <= 1'b0;
      first_word      <= 1'b1;
      word_index      <= '0;
    end else if (accept) begin
      pending_literal <= pending_literal_next;
      pending_tag     <= pending_tag_next;
      pending_hex     <= pending_hex_next;
      first_word      <= 1'b0;
      word_index      <= block_end ? '0 : word_index + 1'b1;
    end
  end

endmodule

@@ rtl/cwsd_queue.sv @@
// ----------------------------------------------------------------------------
// cwsd_queue
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module cwsd_queue import cwsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/cwsd_back.sv @@
// ----------------------------------------------------------------------------
// cwsd_back
// Carries out one command at a time: token start, decoded characters, then
// the number, one result per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module cwsd_back import cwsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_nonempty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [4:0]  tag,
  output logic [6:0]  char_code,
  output logic [31:0] value,
  output logic        hex,
  output logic        last
);

  logic        start_pend, start_pend_next;
  logic        num_pend, num_pend_next;
  logic [27:0] text, text_next;
  logic [4:0]  cur_tag;
  logic [31:0] cur_value;
  logic        cur_hex;

  logic        busy, out_free, emit;
  logic [5:0]  idx;
  logic [27:0] text_step;
  logic [2:0]  hi_group;
  logic [1:0]  emit_kind;
  logic        emit_last;

  assign busy     = start_pend || (text != '0) || num_pend;
  assign out_free = !result_valid || !result_stall;
  assign emit     = busy && out_free;
  assign q_pop    = !busy && q_nonempty;
  assign hi_group = {1'b0, text[25:24]} + 3'd2;

  // one prefix code off the top of the remaining text
  always_comb begin
    if (!text[27]) begin
      idx       = {2'b00, text[27:24]};
      text_step = {text[23:0], 4'b0};
    end else if (text[27:26] == 2'b10) begin
      idx       = {3'b001, text[25:23]};
      text_step = {text[22:0], 5'b0};
    end else begin
      idx       = {hi_group, text[23:21]};
      text_step = {text[20:0], 7'b0};
    end
  end

  always_comb begin
    start_pend_next = start_pend;
    num_pend_next   = num_pend;
    text_next       = text;
    emit_kind       = KIND_START;
    if (start_pend) begin
      start_pend_next = 1'b0;
      emit_kind       = KIND_START;
    end else if (text != '0) begin
      text_next = text_step;
      emit_kind = KIND_CHAR;
    end else begin
      num_pend_next = 1'b0;
      emit_kind     = KIND_NUM;
    end
    emit_last = !(start_pend_next || (text_next != '0) || num_pend_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pend <= 1'b0;
      num_pend   <= 1'b0;
      text       <= '0;
    end else if (q_pop) begin
      start_pend <= q_cmd.has_start;
      num_pend   <= q_cmd.has_num;
      text       <= q_cmd.text;
    end else if (emit) begin
      start_pend <= start_pend_next;
      num_pend   <= num_pend_next;
      text       <= text_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_tag   <= q_cmd.tag;
      cur_value <= q_cmd.value;
      cur_hex   <= q_cmd.hex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind      <= emit_kind;
      tag       <= cur_tag;
      char_code <= (emit_kind == KIND_CHAR) ? sym_char(idx) : 7'd0;
      value     <= (emit_kind == KIND_NUM) ? cur_value : 32'd0;
      hex       <= (emit_kind == KIND_NUM) ? cur_hex : 1'b0;
      last      <= emit_last;
    end
  end

endmodule
